// ===== rtl/prqs_pkg.sv =====
// Package: shared types and constants of the policy ready queue scheduler.
`timescale 1ns / 1ps
package prqs_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int NUM_THREADS_DEF = 16;
	localparam int TOT_W = 48;

	typedef enum logic [1:0] {
		POL_FCFS     = 2'd0,
		POL_SJF      = 2'd1,
		POL_PRIO     = 2'd2,
		POL_VRUNTIME = 2'd3
	} policy_e;

	typedef enum logic [1:0] {
		ST_INSERTED   = 2'd0,
		ST_DISPATCHED = 2'd1,
		ST_EMPTY      = 2'd2,
		ST_FULL       = 2'd3
	} status_e;

	typedef enum logic {
		KIND_INSERT   = 1'b0,
		KIND_RETRIEVE = 1'b1
	} kind_e;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_SCAN,
		S_UPD_RD,
		S_UPD_WR,
		S_OUT
	} state_e;

	typedef struct packed {
		logic        kind;
		logic [3:0]  thread_id;
		logic [15:0] burst_number;
		logic [15:0] burst_length;
		logic [31:0] timestamp;
	} in_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [3:0]       picked_thread;
		logic [15:0]      picked_burst_number;
		logic [15:0]      picked_burst_length;
		logic [31:0]      waiting_time;
		logic [TOT_W-1:0] thread_wait_sum;
		logic [6:0]       queue_count;
	} out_t;

	typedef struct packed {
		logic [3:0]  thread;
		logic [15:0] bnum;
		logic [15:0] blen;
		logic [31:0] created;
		logic [31:0] seq;
	} slot_t;

	typedef struct packed {
		logic [TOT_W-1:0] vr;
		logic [TOT_W-1:0] wt;
	} tot_t;

endpackage

// ===== rtl/policy_ready_queue_scheduler_unit.sv =====
// Top level: policy ready queue scheduler with slot scan and thread table update.
// Insert: the free slot search checks one slot a cycle until it finds a free one.
// Retrieve: a scan reads one slot a cycle from slot memory.
// Full insert or empty retrieve: no search or scan. One transaction in work at a time.
// The result register lets the next transaction be accepted while a result waits.
// Reset (arst_n low, asynchronous) empties the queue, zeroes thread totals and policy.
`timescale 1ns / 1ps
module policy_ready_queue_scheduler_unit #(
	parameter int QUEUE_DEPTH = prqs_pkg::QUEUE_DEPTH_DEF,
	parameter int NUM_THREADS = prqs_pkg::NUM_THREADS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  prqs_pkg::in_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output prqs_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_wdata
);
	import prqs_pkg::*;

	localparam int IW  = $clog2(QUEUE_DEPTH);
	localparam int OW  = $clog2(QUEUE_DEPTH + 1);
	localparam int TIW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;

	state_e                 state_q, state_d;
	policy_e                policy_q;
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [NUM_THREADS-1:0] tvalid_q;
	logic [OW-1:0]          occ_q;
	logic [31:0]            arr_q;
	logic [IW-1:0]          cnt_q;
	logic                   issue_q;
	logic                   p1_q, p2_q;
	logic [IW-1:0]          idx_s1, idx_s2;
	logic                   sv_s1, sv_s2;
	logic                   tv_s2;
	slot_t                  slot_s2;
	logic                   found_q;
	logic [TOT_W-1:0]       bkey_q;
	logic [31:0]            bage_q;
	logic [IW-1:0]          bidx_q;
	slot_t                  bslot_q;
	logic [TIW-1:0]         bt_q;
	logic [21:0]            prod_q;
	in_t                    req_q;
	out_t                   res_q, out_q;
	out_t                   res_out;
	logic                   out_valid_q;

	logic [TIW-1:0] tmod_tab [16];
	for (genvar k = 0; k < 16; k++) begin : g_tmod
		assign tmod_tab[k] = TIW'(k % NUM_THREADS);
	end

	logic           in_fire, out_load, full, empty;
	logic           s_we, t_we;
	logic [IW-1:0]  s_raddr;
	slot_t          s_wdata, s_rdata;
	logic [TIW-1:0] t_raddr, t_sidx;
	tot_t           t_wdata, t_rdata, t_base;
	logic [TOT_W-1:0] key_s2;
	logic [31:0]    age_s2, wait_c;
	logic           better;
	logic [5:0]     weight;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign full      = (occ_q == OW'(QUEUE_DEPTH));
	assign empty     = (occ_q == '0);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign t_sidx  = tmod_tab[s_rdata.thread];
	assign s_raddr = cnt_q;
	assign t_raddr = (state_q == S_UPD_RD) ? tmod_tab[bslot_q.thread] : t_sidx;
	assign wait_c  = req_q.timestamp - bslot_q.created;
	assign t_base  = tvalid_q[bt_q] ? t_rdata : '0;
	assign weight  = 6'd7 + 6'd3 * {2'b00, bslot_q.thread};
	assign age_s2  = arr_q - slot_s2.seq;

	always_comb begin
		unique case (policy_q)
			POL_FCFS:     key_s2 = '0;
			POL_SJF:      key_s2 = TOT_W'(slot_s2.blen);
			POL_PRIO:     key_s2 = TOT_W'(slot_s2.thread);
			POL_VRUNTIME: key_s2 = tv_s2 ? t_rdata.vr : '0;
			default:      key_s2 = '0;
		endcase
	end

	assign better = !found_q || (key_s2 < bkey_q) || ((key_s2 == bkey_q) && (age_s2 > bage_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (in_data.kind == KIND_RETRIEVE) begin
						state_d = empty ? S_OUT : S_SCAN;
					end else begin
						state_d = full ? S_OUT : S_FIND;
					end
				end
			end
			S_FIND:   state_d = valid_q[cnt_q] ? S_FIND : S_OUT;
			S_SCAN:   state_d = (!issue_q && !p1_q && !p2_q) ? S_UPD_RD : S_SCAN;
			S_UPD_RD: state_d = S_UPD_WR;
			S_UPD_WR: state_d = S_OUT;
			S_OUT:    state_d = out_load ? S_IDLE : S_OUT;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_we    = (state_q == S_FIND) && !valid_q[cnt_q];
		s_wdata = '{thread: req_q.thread_id, bnum: req_q.burst_number,
			blen: req_q.burst_length, created: req_q.timestamp, seq: arr_q};
		t_we    = (state_q == S_UPD_WR);
		t_wdata = '{vr: t_base.vr + TOT_W'(prod_q), wt: t_base.wt + TOT_W'(wait_c)};
	end

	always_comb begin
		res_out             = res_q;
		res_out.queue_count = 7'(occ_q);
	end

	prqs_slot_mem #(.DEPTH(QUEUE_DEPTH)) u_slot (
		.clk(clk), .we(s_we), .waddr(cnt_q), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	prqs_thread_mem #(.DEPTH(NUM_THREADS), .AW(TIW)) u_thread (
		.clk(clk), .we(t_we), .waddr(bt_q), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			policy_q    <= POL_FCFS;
			valid_q     <= '0;
			tvalid_q    <= '0;
			occ_q       <= '0;
			arr_q       <= '0;
			issue_q     <= 1'b0;
			p1_q        <= 1'b0;
			p2_q        <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				policy_q <= policy_e'(cfg_wdata);
			end
			p1_q <= (state_q == S_SCAN) && issue_q;
			p2_q <= p1_q;
			if (in_fire) begin
				issue_q <= (in_data.kind == KIND_RETRIEVE) && !empty;
				found_q <= 1'b0;
			end else if ((state_q == S_SCAN) && issue_q && (cnt_q == IW'(QUEUE_DEPTH - 1))) begin
				issue_q <= 1'b0;
			end
			if (p2_q && sv_s2 && better) begin
				found_q <= 1'b1;
			end
			if (s_we) begin
				valid_q[cnt_q] <= 1'b1;
				arr_q          <= arr_q + 32'd1;
				occ_q          <= occ_q + OW'(1);
			end
			if (state_q == S_UPD_WR) begin
				tvalid_q[bt_q]   <= 1'b1;
				valid_q[bidx_q]  <= 1'b0;
				occ_q            <= occ_q - OW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q <= in_data;
			cnt_q <= '0;
			res_q <= '{status: (in_data.kind == KIND_RETRIEVE) ?
				(empty ? ST_EMPTY : ST_DISPATCHED) : (full ? ST_FULL : ST_INSERTED),
				default: '0};
		end else if (((state_q == S_FIND) && valid_q[cnt_q]) ||
				((state_q == S_SCAN) && issue_q)) begin
			cnt_q <= cnt_q + IW'(1);
		end
		idx_s1 <= cnt_q;
		sv_s1  <= valid_q[cnt_q];
		idx_s2 <= idx_s1;
		sv_s2  <= sv_s1;
		slot_s2 <= s_rdata;
		tv_s2  <= tvalid_q[t_sidx];
		if (p2_q && sv_s2 && better) begin
			bkey_q  <= key_s2;
			bage_q  <= age_s2;
			bidx_q  <= idx_s2;
			bslot_q <= slot_s2;
		end
		if (state_q == S_UPD_RD) begin
			bt_q   <= tmod_tab[bslot_q.thread];
			prod_q <= 22'(bslot_q.blen) * 22'(weight);
		end
		if (state_q == S_UPD_WR) begin
			res_q.picked_thread       <= bslot_q.thread;
			res_q.picked_burst_number <= bslot_q.bnum;
			res_q.picked_burst_length <= bslot_q.blen;
			res_q.waiting_time        <= wait_c;
			res_q.thread_wait_sum     <= t_wdata.wt;
		end
		if (out_load) begin
			out_q <= res_out;
		end
	end

`ifndef SYNTHESIS
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("occupancy does not match valid slots");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(QUEUE_DEPTH))
		else $error("occupancy above queue depth");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.status == ST_EMPTY) |->
		(out_q.waiting_time == '0) && (out_q.thread_wait_sum == '0))
		else $error("empty retrieve carries payload");

	a_scan_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD_RD) |-> found_q)
		else $error("retrieve scan found no entry");
`endif

endmodule

// ===== rtl/prqs_slot_mem.sv =====
// Slot memory: one entry per queued burst, one write and one registered read port.
`timescale 1ns / 1ps
module prqs_slot_mem #(
	parameter int DEPTH = prqs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  prqs_pkg::slot_t          wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output prqs_pkg::slot_t          rdata
);
	import prqs_pkg::*;

	slot_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/prqs_thread_mem.sv =====
// Thread table: per-thread vruntime and wait total, one write and one registered read port.
`timescale 1ns / 1ps
module prqs_thread_mem #(
	parameter int DEPTH = prqs_pkg::NUM_THREADS_DEF,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  prqs_pkg::tot_t wdata,
	input  logic [AW-1:0]  raddr,
	output prqs_pkg::tot_t rdata
);
	import prqs_pkg::*;

	tot_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench: directed and randomized insert/retrieve traffic against a scoreboard predictor of the scheduler.
`timescale 1ns / 1ps
module testbench;
	import prqs_pkg::*;

	localparam int DEPTH = 64;
	localparam int NTHR = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	class sched_scoreboard;
		bit          valid[DEPTH];
		logic [3:0]  thr[DEPTH];
		logic [15:0] bnum[DEPTH];
		logic [15:0] blen[DEPTH];
		logic [31:0] created[DEPTH];
		logic [31:0] seq[DEPTH];
		logic [31:0] arrivals;
		int          held;
		logic [47:0] vrun[NTHR];
		logic [47:0] wsum[NTHR];
		policy_e     pol;
		out_t        pending[$];
		int          errors;
		int          dispatched;
		int          fulls;
		int          empties;

		function new();
			for (int i = 0; i < DEPTH; i++) valid[i] = 0;
			for (int i = 0; i < NTHR; i++) begin
				vrun[i] = '0;
				wsum[i] = '0;
			end
			arrivals = '0;
			held = 0;
			pol = POL_FCFS;
			errors = 0;
			dispatched = 0;
			fulls = 0;
			empties = 0;
		endfunction

		function logic [47:0] key(int i);
			case (pol)
				POL_SJF: return 48'(blen[i]);
				POL_PRIO: return 48'(thr[i]);
				POL_VRUNTIME: return vrun[thr[i]];
				default: return '0;
			endcase
		endfunction

		function void note_input(in_t it);
			out_t r;
			int best;
			int k;
			r = '0;
			best = -1;
			if (it.kind == KIND_INSERT) begin
				if (held >= DEPTH) begin
					r.status = ST_FULL;
					fulls++;
				end else begin
					k = 0;
					while (valid[k]) k++;
					valid[k] = 1;
					thr[k] = it.thread_id;
					bnum[k] = it.burst_number;
					blen[k] = it.burst_length;
					created[k] = it.timestamp;
					seq[k] = arrivals;
					arrivals++;
					held++;
					r.status = ST_INSERTED;
				end
			end else begin
				for (int i = 0; i < DEPTH; i++) begin
					if (!valid[i]) continue;
					if (best < 0) best = i;
					else if (key(i) < key(best) || (key(i) == key(best) &&
							(arrivals - seq[i]) > (arrivals - seq[best])))
						best = i;
				end
				if (best < 0) begin
					r.status = ST_EMPTY;
					empties++;
				end else begin
					r.status = ST_DISPATCHED;
					r.picked_thread = thr[best];
					r.picked_burst_number = bnum[best];
					r.picked_burst_length = blen[best];
					r.waiting_time = it.timestamp - created[best];
					wsum[thr[best]] = wsum[thr[best]] + 48'(r.waiting_time);
					vrun[thr[best]] = vrun[thr[best]] +
						48'(blen[best]) * (48'd7 + 48'd3 * 48'(thr[best]));
					r.thread_wait_sum = wsum[thr[best]];
					valid[best] = 0;
					held--;
					dispatched++;
				end
			end
			r.queue_count = 7'(held);
			pending.push_back(r);
		endfunction

		task automatic report(string what, logic [63:0] got, logic [63:0] exp);
			$display("mismatch %s: got %0h expected %0h", what, got, exp);
			errors++;
		endtask

		task automatic check_result(out_t got);
			out_t e;
			if (pending.size() == 0) begin
				report("unexpected transaction", 64'(got), 64'd0);
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status)
				report("status", 64'(got.status), 64'(e.status));
			if (got.picked_thread !== e.picked_thread)
				report("picked_thread", 64'(got.picked_thread), 64'(e.picked_thread));
			if (got.picked_burst_number !== e.picked_burst_number)
				report("picked_burst_number", 64'(got.picked_burst_number),
					64'(e.picked_burst_number));
			if (got.picked_burst_length !== e.picked_burst_length)
				report("picked_burst_length", 64'(got.picked_burst_length),
					64'(e.picked_burst_length));
			if (got.waiting_time !== e.waiting_time)
				report("waiting_time", 64'(got.waiting_time), 64'(e.waiting_time));
			if (got.thread_wait_sum !== e.thread_wait_sum)
				report("thread_wait_sum", 64'(got.thread_wait_sum), 64'(e.thread_wait_sum));
			if (got.queue_count !== e.queue_count)
				report("queue_count", 64'(got.queue_count), 64'(e.queue_count));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;
	logic cfg_we;
	logic [1:0] cfg_wdata;

	sched_scoreboard sb;
	int idle_cycles;
	logic [31:0] now_ms;

	policy_ready_queue_scheduler_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_result(out_data);
	end

	// receiver stalls
	initial begin
		int wait_n;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			if (wait_n > 0) begin
				out_ready <= 0;
				repeat (wait_n) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send(kind_e k, logic [3:0] t, logic [15:0] bn, logic [15:0] bl,
			logic [31:0] ts, bit gaps);
		in_t it;
		int gap;
		gap = gaps ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		it.kind = k;
		it.thread_id = t;
		it.burst_number = bn;
		it.burst_length = bl;
		it.timestamp = ts;
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(it);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DEPTH + 10) @(posedge clk);
	endtask

	task automatic set_policy(policy_e p);
		drain();
		cfg_we <= 1;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_we <= 0;
		sb.pol = p;
	endtask

	task automatic random_item(int insert_pct, bit gaps);
		logic [15:0] bl;
		now_ms = now_ms + $urandom_range(0, 50);
		bl = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
		if ($urandom_range(0, 99) < insert_pct)
			send(KIND_INSERT, 4'($urandom), 16'($urandom), bl,
				($urandom_range(0, 15) == 0) ? $urandom : now_ms, gaps);
		else
			send(KIND_RETRIEVE, 4'($urandom), 16'($urandom), 16'($urandom),
				($urandom_range(0, 15) == 0) ? $urandom : now_ms, gaps);
	endtask

	initial begin
		policy_e pols[4];
		bit gaps;
		sb = new();
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_wdata = '0;
		idle_cycles = 0;
		now_ms = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty, extremes, wraparound wait
		send(KIND_RETRIEVE, 4'd0, 16'd0, 16'd0, 32'd0, 0);
		send(KIND_INSERT, 4'hF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
		send(KIND_INSERT, 4'h0, 16'h0, 16'h0, 32'h0, 0);
		send(KIND_INSERT, 4'h5, 16'h1234, 16'h0, 32'h10, 0);
		send(KIND_RETRIEVE, 4'hF, 16'hFFFF, 16'hFFFF, 32'h5, 0);
		set_policy(POL_SJF);
		send(KIND_RETRIEVE, 4'h0, 16'h0, 16'h0, 32'hFFFF_FFFF, 0);
		set_policy(POL_PRIO);
		send(KIND_RETRIEVE, 4'h0, 16'h0, 16'h0, 32'h0, 0);
		send(KIND_RETRIEVE, 4'h0, 16'h0, 16'h0, 32'h0, 0);
		// fill to full and overflow
		for (int i = 0; i < DEPTH + 2; i++)
			send(KIND_INSERT, 4'(i), 16'(i), 16'(i * 7), 32'(i), 0);
		set_policy(POL_VRUNTIME);
		for (int i = 0; i < 8; i++) send(KIND_RETRIEVE, 4'h0, 16'h0, 16'h0, 32'd100, 0);

		pols[0] = POL_FCFS; pols[1] = POL_SJF; pols[2] = POL_PRIO; pols[3] = POL_VRUNTIME;
		for (int ph = 0; ph < 8; ph++) begin
			set_policy(pols[$urandom_range(0, 3)]);
			if (ph < 4) set_policy(pols[ph]);
			gaps = (ph % 3) != 2;
			for (int n = 0; n < 205; n++)
				random_item((ph == 5) ? 75 : ((ph == 6) ? 30 : 52), gaps);
		end
		drain();
		$display("covered %0d dispatches, %0d full inserts, %0d empty retrieves",
			sb.dispatched, sb.fulls, sb.empties);
		$display("all four policies exercised with random handshake stalls");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
